// ===== design/rvx_pkg.sv =====
// Package for the RV32IM execute block: opcodes, CSR numbers, state and result types.
// Used by every module in the design folder; has no dependencies.
package rvx_pkg;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [11:0] CSR_MEPC    = 12'h341;
    localparam logic [11:0] CSR_MTVEC   = 12'h305;
    localparam logic [11:0] CSR_MSTATUS = 12'h300;
    localparam logic [11:0] CSR_MCAUSE  = 12'h342;

    localparam logic [31:0] WORD_MRET   = 32'h30200073;
    localparam logic [31:0] WORD_ECALL  = 32'h00000073;
    localparam logic [31:0] WORD_EBREAK = 32'h00100073;
    localparam logic [31:0] CAUSE_ECALL = 32'h0000000b;
    localparam logic [31:0] BOOT_RESET  = 32'h80000000;
    localparam logic [31:0] JALR_MASK   = 32'hFFFFFFFE;

    localparam logic        CMD_EXEC = 1'b0;
    localparam logic        CMD_LOAD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DIV,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic        is_signed;
        logic        want_rem;
    } div_ctl_t;

    typedef struct packed {
        logic        busy;
        logic        done;
    } div_sts_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] mem_address;
        logic [1:0]  mem_size;
        logic [31:0] write_data;
        logic        trap_taken;
        logic        halted;
        logic [31:0] halt_code;
        logic        illegal;
    } result_t;

    localparam int RESULT_W = 32 + 1 + 1 + 32 + 2 + 32 + 1 + 1 + 32 + 1;
    localparam int RES_BYTES_W = ((RESULT_W + 7) / 8) * 8;
    localparam int IN_W = 64;

endpackage

// ===== design/rvx_regfile.sv =====
// Register file of 32 words with two registered read ports and one write port.
// Depends on rvx_pkg; entries clear through valid bits at reset, x0 reads zero.
module rvx_regfile
    import rvx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [4:0]  raddr_a,
    input  logic [4:0]  raddr_b,
    output logic [31:0] rdata_a,
    output logic [31:0] rdata_b,
    input  logic        we,
    input  logic [4:0]  waddr,
    input  logic [31:0] wdata
);

    logic [31:0] mem [32];
    logic [31:0] valid_reg;
    logic [31:0] ra_reg;
    logic [31:0] rb_reg;
    logic        va_reg;
    logic        vb_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        ra_reg <= mem[raddr_a];
        rb_reg <= mem[raddr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end
        else
        begin
            if (we && waddr != 5'd0)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            va_reg <= valid_reg[raddr_a] && raddr_a != 5'd0;
            vb_reg <= valid_reg[raddr_b] && raddr_b != 5'd0;
        end
    end

    assign rdata_a = va_reg ? ra_reg : 32'd0;
    assign rdata_b = vb_reg ? rb_reg : 32'd0;

endmodule

// ===== design/rvx_divider.sv =====
// Radix-2 restoring divider, one quotient bit a cycle, with the RISC-V rules
// for divide by zero and signed overflow. Depends on rvx_pkg.
module rvx_divider
    import rvx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_ctl_t    ctl,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output div_sts_t    sts,
    output logic [31:0] result
);

    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        negq_reg, negq_next;
    logic        negr_reg, negr_next;
    logic        rem_sel_reg, rem_sel_next;
    logic        zero_reg, zero_next;
    logic [31:0] orig_reg, orig_next;
    logic [32:0] trial;
    logic [31:0] ua;
    logic [31:0] ub;
    logic        na;
    logic        nb;
    logic [31:0] q_fix;
    logic [31:0] r_fix;

    always_comb
    begin
        na = ctl.is_signed && dividend[31];
        nb = ctl.is_signed && divisor[31];
        ua = na ? (32'd0 - dividend) : dividend;
        ub = nb ? (32'd0 - divisor) : divisor;
        trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};

        quo_next     = quo_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        negq_next    = negq_reg;
        negr_next    = negr_reg;
        rem_sel_next = rem_sel_reg;
        zero_next    = zero_reg;
        orig_next    = orig_reg;

        if (ctl.start)
        begin
            quo_next     = ua;
            rem_next     = 32'd0;
            dvs_next     = ub;
            cnt_next     = 6'd32;
            busy_next    = 1'b1;
            negq_next    = na ^ nb;
            negr_next    = na;
            rem_sel_next = ctl.want_rem;
            zero_next    = divisor == 32'd0;
            orig_next    = dividend;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end

        q_fix = negq_reg ? (32'd0 - quo_reg) : quo_reg;
        r_fix = negr_reg ? (32'd0 - rem_reg) : rem_reg;
        if (zero_reg)
        begin
            result = rem_sel_reg ? orig_reg : 32'hFFFFFFFF;
        end
        else
        begin
            result = rem_sel_reg ? r_fix : q_fix;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        negq_reg    <= negq_next;
        negr_reg    <= negr_next;
        rem_sel_reg <= rem_sel_next;
        zero_reg    <= zero_next;
        orig_reg    <= orig_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

// ===== design/rv32im_decode_execute_core.sv =====
// Top level of the RV32IM execute block: sequencer, ALU, CSRs and result register.
// Depends on rvx_pkg, rvx_regfile and rvx_divider.
// Handles one beat at a time; s_axis_tready is low from acceptance until the
// result beat is taken. Divides and remainders wait for the divider in ST_DIV.
// The register file read port is the first step of every beat.
// Reset clears pc to 0x80000000, CSRs, pending load and halt state; registers read zero.
module rv32im_decode_execute_core
    import rvx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: instruction[31:0], load_data[63:32]
    input  logic [63:0] s_axis_tdata,
    // tuser: command
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: next_pc, mem_read, mem_write, mem_address, mem_size, write_data,
    // trap_taken, halted, halt_code, illegal, then zero fill
    output logic [RES_BYTES_W-1:0] m_axis_tdata
);

    state_t      state_reg, state_next;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] mepc_reg, mepc_next;
    logic [31:0] mtvec_reg, mtvec_next;
    logic [31:0] mstatus_reg, mstatus_next;
    logic [31:0] mcause_reg, mcause_next;
    logic [8:0]  pend_reg, pend_next;
    logic        stop_reg, stop_next;
    logic [31:0] ins_reg, ins_next;
    logic [31:0] ld_reg, ld_next;
    logic        cmd_reg, cmd_next;
    result_t     res_reg, res_next;
    logic        we_reg, we_next;
    logic [4:0]  wa_reg, wa_next;
    logic [31:0] wd_reg, wd_next;
    logic        out_ok_reg;

    logic [31:0] a;
    logic [31:0] b;
    logic [4:0]  ra_sel;
    logic [4:0]  rb_sel;
    div_ctl_t    dctl;
    div_sts_t    dsts;
    logic [31:0] dres;

    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;
    logic [31:0] snpc;
    logic [31:0] csr_old;
    logic        csr_ok;
    logic [63:0] prod;
    logic [31:0] mulh;
    logic        take;
    logic [31:0] lv;

    rvx_regfile u_rf (
        .clk     (clk),
        .rst_n   (rst_n),
        .raddr_a (ra_sel),
        .raddr_b (rb_sel),
        .rdata_a (a),
        .rdata_b (b),
        .we      (we_reg),
        .waddr   (wa_reg),
        .wdata   (wd_reg)
    );

    rvx_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (dctl),
        .dividend (a),
        .divisor  (b),
        .sts      (dsts),
        .result   (dres)
    );

    assign op    = ins_reg[6:0];
    assign rd    = ins_reg[11:7];
    assign f3    = ins_reg[14:12];
    assign rs1   = ins_reg[19:15];
    assign rs2   = ins_reg[24:20];
    assign f7    = ins_reg[31:25];
    assign imm_i = {{20{ins_reg[31]}}, ins_reg[31:20]};
    assign imm_s = {{20{ins_reg[31]}}, ins_reg[31:25], ins_reg[11:7]};
    assign imm_b = {{19{ins_reg[31]}}, ins_reg[31], ins_reg[7], ins_reg[30:25],
                    ins_reg[11:8], 1'b0};
    assign imm_j = {{11{ins_reg[31]}}, ins_reg[31], ins_reg[19:12], ins_reg[20],
                    ins_reg[30:21], 1'b0};
    assign imm_u = {ins_reg[31:12], 12'd0};
    assign snpc  = pc_reg + 32'd4;
    assign ra_sel = (state_reg == ST_WRITE || state_reg == ST_OUT) ? 5'd10 : rs1;
    assign rb_sel = rs2;

    always_comb
    begin
        prod = {32'd0, a} * {32'd0, b};
        mulh = prod[63:32] - (a[31] ? b : 32'd0) - (b[31] ? a : 32'd0);
    end

    always_comb
    begin
        csr_ok  = 1'b1;
        csr_old = 32'd0;
        case (ins_reg[31:20])
            CSR_MEPC:    csr_old = mepc_reg;
            CSR_MTVEC:   csr_old = mtvec_reg;
            CSR_MSTATUS: csr_old = mstatus_reg;
            CSR_MCAUSE:  csr_old = mcause_reg;
            default:     csr_ok  = 1'b0;
        endcase
    end

    always_comb
    begin
        case (pend_reg[7:5])
            3'd0:    lv = {{24{ld_reg[7]}}, ld_reg[7:0]};
            3'd1:    lv = {{16{ld_reg[15]}}, ld_reg[15:0]};
            3'd4:    lv = {24'd0, ld_reg[7:0]};
            3'd5:    lv = {16'd0, ld_reg[15:0]};
            default: lv = ld_reg;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        mepc_next    = mepc_reg;
        mtvec_next   = mtvec_reg;
        mstatus_next = mstatus_reg;
        mcause_next  = mcause_reg;
        pend_next    = pend_reg;
        stop_next    = stop_reg;
        ins_next     = ins_reg;
        ld_next      = ld_reg;
        cmd_next     = cmd_reg;
        res_next     = res_reg;
        we_next      = 1'b0;
        wa_next      = wa_reg;
        wd_next      = wd_reg;
        dctl         = '0;
        take         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ins_next   = s_axis_tdata[31:0];
                    ld_next    = s_axis_tdata[63:32];
                    cmd_next   = s_axis_tuser;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                res_next         = '0;
                res_next.next_pc = pc_reg;
                wa_next          = rd;
                state_next       = ST_WRITE;
                if (stop_reg)
                begin
                    res_next.halted = 1'b1;
                end
                else if (cmd_reg == CMD_LOAD)
                begin
                    if (pend_reg[8])
                    begin
                        we_next   = 1'b1;
                        wa_next   = pend_reg[4:0];
                        wd_next   = lv;
                        pend_next = 9'd0;
                    end
                end
                else
                begin
                    pend_next        = 9'd0;
                    res_next.next_pc = snpc;
                    case (op)
                        OP_LUI:
                        begin
                            we_next = 1'b1;
                            wd_next = imm_u;
                        end
                        OP_AUIPC:
                        begin
                            we_next = 1'b1;
                            wd_next = imm_u + pc_reg;
                        end
                        OP_JAL:
                        begin
                            we_next = 1'b1;
                            wd_next = snpc;
                            res_next.next_pc = pc_reg + imm_j;
                        end
                        OP_JALR:
                        begin
                            if (f3 != 3'd0)
                            begin
                                res_next.illegal = 1'b1;
                            end
                            else
                            begin
                                we_next = 1'b1;
                                wd_next = snpc;
                                res_next.next_pc = (a + imm_i) & JALR_MASK;
                            end
                        end
                        OP_LOAD:
                        begin
                            if (f3 == 3'd3 || f3 > 3'd5)
                            begin
                                res_next.illegal = 1'b1;
                            end
                            else
                            begin
                                res_next.mem_read    = 1'b1;
                                res_next.mem_address = a + imm_i;
                                res_next.mem_size    = f3[1:0];
                                pend_next = {1'b1, f3, rd};
                            end
                        end
                        OP_STORE:
                        begin
                            if (f3 > 3'd2)
                            begin
                                res_next.illegal = 1'b1;
                            end
                            else
                            begin
                                res_next.mem_write   = 1'b1;
                                res_next.mem_address = a + imm_s;
                                res_next.mem_size    = f3[1:0];
                                res_next.write_data  = b;
                            end
                        end
                        OP_IMM:
                        begin
                            we_next = 1'b1;
                            case (f3)
                                3'd0: wd_next = a + imm_i;
                                3'd2: wd_next = {31'd0, $signed(a) < $signed(imm_i)};
                                3'd3: wd_next = {31'd0, a < imm_i};
                                3'd4: wd_next = a ^ imm_i;
                                3'd6: wd_next = a | imm_i;
                                3'd7: wd_next = a & imm_i;
                                3'd1:
                                begin
                                    wd_next = a << rs2;
                                    if (f7 != 7'h00)
                                    begin
                                        we_next = 1'b0;
                                        res_next.illegal = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    if (f7 == 7'h00)
                                    begin
                                        wd_next = a >> rs2;
                                    end
                                    else if (f7 == 7'h20)
                                    begin
                                        wd_next = 32'($signed(a) >>> rs2);
                                    end
                                    else
                                    begin
                                        we_next = 1'b0;
                                        res_next.illegal = 1'b1;
                                    end
                                end
                            endcase
                        end
                        OP_BRANCH:
                        begin
                            case (f3)
                                3'd0: take = a == b;
                                3'd1: take = a != b;
                                3'd4: take = $signed(a) < $signed(b);
                                3'd5: take = $signed(a) >= $signed(b);
                                3'd6: take = a < b;
                                3'd7: take = a >= b;
                                default: res_next.illegal = 1'b1;
                            endcase
                            if (take)
                            begin
                                res_next.next_pc = pc_reg + imm_b;
                            end
                        end
                        OP_REG:
                        begin
                            we_next = 1'b1;
                            if (f7 == 7'h00)
                            begin
                                case (f3)
                                    3'd0: wd_next = a + b;
                                    3'd1: wd_next = a << b[4:0];
                                    3'd2: wd_next = {31'd0, $signed(a) < $signed(b)};
                                    3'd3: wd_next = {31'd0, a < b};
                                    3'd4: wd_next = a ^ b;
                                    3'd5: wd_next = a >> b[4:0];
                                    3'd6: wd_next = a | b;
                                    default: wd_next = a & b;
                                endcase
                            end
                            else if (f7 == 7'h20 && f3 == 3'd0)
                            begin
                                wd_next = a - b;
                            end
                            else if (f7 == 7'h20 && f3 == 3'd5)
                            begin
                                wd_next = 32'($signed(a) >>> b[4:0]);
                            end
                            else if (f7 == 7'h01)
                            begin
                                case (f3)
                                    3'd0: wd_next = prod[31:0];
                                    3'd1: wd_next = mulh;
                                    3'd3: wd_next = prod[63:32];
                                    3'd2:
                                    begin
                                        we_next = 1'b0;
                                        res_next.illegal = 1'b1;
                                    end
                                    default:
                                    begin
                                        we_next = 1'b0;
                                        dctl.start     = 1'b1;
                                        dctl.is_signed = !f3[0];
                                        dctl.want_rem  = f3[1];
                                        state_next     = ST_DIV;
                                    end
                                endcase
                            end
                            else
                            begin
                                we_next = 1'b0;
                                res_next.illegal = 1'b1;
                            end
                        end
                        OP_SYSTEM:
                        begin
                            if (f3 == 3'd1 || f3 == 3'd2)
                            begin
                                if (!csr_ok)
                                begin
                                    res_next.illegal = 1'b1;
                                end
                                else
                                begin
                                    we_next = 1'b1;
                                    wd_next = csr_old;
                                    if (f3 == 3'd1 || rs1 != 5'd0)
                                    begin
                                        case (ins_reg[31:20])
                                            CSR_MEPC:
                                                mepc_next = (f3 == 3'd1) ? a : csr_old | a;
                                            CSR_MTVEC:
                                                mtvec_next = (f3 == 3'd1) ? a : csr_old | a;
                                            CSR_MSTATUS:
                                                mstatus_next = (f3 == 3'd1) ? a : csr_old | a;
                                            default:
                                                mcause_next = (f3 == 3'd1) ? a : csr_old | a;
                                        endcase
                                    end
                                end
                            end
                            else if (ins_reg == WORD_MRET)
                            begin
                                res_next.next_pc = mepc_reg;
                            end
                            else if (ins_reg == WORD_ECALL)
                            begin
                                mepc_next   = pc_reg;
                                mcause_next = CAUSE_ECALL;
                                res_next.next_pc    = mtvec_reg;
                                res_next.trap_taken = 1'b1;
                            end
                            else if (ins_reg == WORD_EBREAK)
                            begin
                                stop_next       = 1'b1;
                                res_next.halted = 1'b1;
                            end
                            else
                            begin
                                res_next.illegal = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_next.illegal = 1'b1;
                        end
                    endcase
                    if (res_next.illegal)
                    begin
                        res_next.next_pc = pc_reg;
                    end
                    pc_next = res_next.next_pc;
                end
            end
            ST_DIV:
            begin
                if (dsts.done)
                begin
                    we_next    = 1'b1;
                    wd_next    = dres;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (res_reg.halted)
                begin
                    res_next.halt_code = a;
                end
                if (out_ok_reg && m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            pc_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg <= ins_next;
        ld_reg  <= ld_next;
        cmd_reg <= cmd_next;
        wa_reg  <= wa_next;
        wd_reg  <= wd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pc_reg      <= BOOT_RESET;
            mepc_reg    <= '0;
            mtvec_reg   <= '0;
            mstatus_reg <= '0;
            mcause_reg  <= '0;
            pend_reg    <= '0;
            stop_reg    <= 1'b0;
            res_reg     <= '0;
            we_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            mepc_reg    <= mepc_next;
            mtvec_reg   <= mtvec_next;
            mstatus_reg <= mstatus_next;
            mcause_reg  <= mcause_next;
            pend_reg    <= pend_next;
            stop_reg    <= stop_next;
            res_reg     <= res_next;
            we_reg      <= we_next;
        end
    end

    // The halt code is sampled during the first output cycle, so the beat is
    // shown only once it is settled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ok_reg <= 1'b0;
        end
        else
        begin
            out_ok_reg <= state_reg == ST_OUT && !(out_ok_reg && m_axis_tready);
        end
    end

    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = state_reg == ST_OUT && out_ok_reg;
    assign m_axis_tdata  = {{(RES_BYTES_W - RESULT_W){1'b0}},
                            res_reg.illegal, res_reg.halt_code, res_reg.halted,
                            res_reg.trap_taken, res_reg.write_data, res_reg.mem_size,
                            res_reg.mem_address, res_reg.mem_write, res_reg.mem_read,
                            res_reg.next_pc};

`ifndef SYNTH
    a_busy_no_in: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !s_axis_tready)
        else $error("input ready while busy");
    a_div_only: assert property (@(posedge clk) disable iff (!rst_n)
        dsts.done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide state");
    a_one_mem: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(res_reg.mem_read && res_reg.mem_write))
        else $error("read and write in one beat");
`endif

endmodule
